FILE: sv/kmsd_pkg.sv
// Package for the keypad matrix scan and debounce unit: constants, types and the position table.
package kmsd_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned CfgWidth   = 16;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  localparam logic [4:0] NoKey      = 5'd31;
  localparam logic [2:0] LastColumn = 3'd5;

  localparam logic RegValidCount = 1'b0;
  localparam logic RegKeyEnable  = 1'b1;

  typedef struct packed {
    logic clr;
    logic inc;
  } kmsd_cnt_ctrl_t;

  function automatic logic [4:0] kmsd_position(input logic [4:0] code);
    logic [4:0] pos;
    case (code)
      5'd0:    pos = 5'd17;
      5'd1:    pos = 5'd5;
      5'd2:    pos = 5'd18;
      5'd3:    pos = 5'd14;
      5'd4:    pos = 5'd0;
      5'd5:    pos = 5'd1;
      5'd6:    pos = 5'd16;
      5'd7:    pos = 5'd12;
      5'd8:    pos = 5'd21;
      5'd9:    pos = 5'd23;
      5'd10:   pos = 5'd3;
      5'd11:   pos = 5'd4;
      5'd12:   pos = 5'd15;
      5'd13:   pos = 5'd11;
      5'd14:   pos = 5'd7;
      5'd15:   pos = 5'd22;
      5'd16:   pos = 5'd2;
      5'd17:   pos = 5'd9;
      5'd18:   pos = 5'd20;
      5'd19:   pos = 5'd10;
      5'd20:   pos = 5'd6;
      5'd21:   pos = 5'd19;
      5'd22:   pos = 5'd13;
      5'd23:   pos = 5'd8;
      5'd24:   pos = 5'd24;
      default: pos = 5'd0;
    endcase
    return pos;
  endfunction

endpackage

FILE: sv/kmsd_cnt.sv
// Saturating debounce counter with a reach-threshold strobe.
module kmsd_cnt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kmsd_pkg::kmsd_cnt_ctrl_t      ctrl_i,
  input  logic [kmsd_pkg::CfgWidth-1:0] valid_count_i,
  output logic                          hit_o
);
  import kmsd_pkg::*;

  logic [CountWidth-1:0] cnt_q, cnt_d, cnt_inc;
  logic                  can_inc;

  assign can_inc = (cnt_q != CountMax);
  assign cnt_inc = cnt_q + CountWidth'(1);
  assign hit_o   = ctrl_i.inc && can_inc && (CfgWidth'(cnt_inc) == valid_count_i);

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.clr) begin
      cnt_d = '0;
    end else if (ctrl_i.inc && can_inc) begin
      cnt_d = cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: sv/keypad_matrix_scan_debounce_unit.sv
// Top level of the keypad matrix scan and debounce unit.
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid/tready          tdata: column, row_lines, power_line
//  m_axis    out        tvalid/tready          tdata: key_code; tuser: key_valid, power_event
//  cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One sample per cycle while the output is not stalled; a sample is held in the input
// register, then goes through the debounce logic, whose result lands in the output register.
// Reset is asynchronous, active low, and clears all debounce state and config to defaults.
// A stalled output holds; the input register then accepts a sample only while it is empty.
// The config port is always ready.
module keypad_matrix_scan_debounce_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [2:0] column, [6:3] row_lines, [7] power_line
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [4:0] key_code
  output logic [1:0]  m_axis_tuser,   // [0] key_valid, [1] power_event
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import kmsd_pkg::*;

  logic [CfgWidth-1:0] valid_count_q;
  logic                key_enable_q;

  logic       in_valid_q, in_valid_d;
  logic [2:0] col_q;
  logic [3:0] rows_q;
  logic       pwr_q;
  logic       s_acc, proc;

  logic [4:0] latched_q, latched_d, cand_q, cand_d, latch_eff, code_new;
  logic       seen_q, seen_d;
  logic       row_hit;
  logic [1:0] row_idx;
  logic       col_ok, frame_end;

  kmsd_cnt_ctrl_t key_ctrl, pwr_ctrl;
  logic           key_cnt_hit, pwr_cnt_hit, key_hit, pwr_hit;

  logic       out_valid_q, out_valid_d;
  logic [4:0] out_code_q;
  logic       out_kv_q, out_pe_q;

  // config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_count_q <= CfgWidth'(2);
      key_enable_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegValidCount: valid_count_q <= cfg_data_i;
        RegKeyEnable:  key_enable_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  assign proc          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_acc) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      col_q  <= s_axis_tdata[2:0];
      rows_q <= s_axis_tdata[6:3];
      pwr_q  <= s_axis_tdata[7];
    end
  end

  // row decode and latch
  always_comb begin
    row_hit = 1'b1;
    row_idx = 2'd0;
    unique case (rows_q)
      4'hE:    row_idx = 2'd0;
      4'hD:    row_idx = 2'd1;
      4'hB:    row_idx = 2'd2;
      4'h7:    row_idx = 2'd3;
      default: row_hit = 1'b0;
    endcase
  end

  assign code_new  = {1'b0, row_idx, 2'b00} + {2'b00, row_idx, 1'b0} + {2'b00, col_q};
  assign latch_eff = row_hit ? code_new : latched_q;
  assign col_ok    = (col_q <= LastColumn);
  assign frame_end = proc && (col_q == LastColumn);

  always_comb begin
    latched_d    = latched_q;
    cand_d       = cand_q;
    seen_d       = seen_q;
    key_ctrl     = '0;
    pwr_ctrl     = '0;
    if (proc && col_ok) begin
      latched_d = latch_eff;
    end
    if (frame_end) begin
      latched_d = NoKey;
      if (latch_eff == NoKey) begin
        cand_d       = NoKey;
        key_ctrl.clr = 1'b1;
      end else if (latch_eff == cand_q) begin
        key_ctrl.inc = 1'b1;
      end else begin
        cand_d       = latch_eff;
        key_ctrl.clr = 1'b1;
      end
      if (!pwr_q) begin
        if (seen_q) begin
          pwr_ctrl.inc = 1'b1;
        end else begin
          seen_d       = 1'b1;
          pwr_ctrl.clr = 1'b1;
        end
      end else begin
        seen_d       = 1'b0;
        pwr_ctrl.clr = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q <= NoKey;
      cand_q    <= NoKey;
      seen_q    <= 1'b0;
    end else begin
      latched_q <= latched_d;
      cand_q    <= cand_d;
      seen_q    <= seen_d;
    end
  end

  kmsd_cnt u_key_cnt (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (key_ctrl),
    .valid_count_i (valid_count_q),
    .hit_o         (key_cnt_hit)
  );

  kmsd_cnt u_pwr_cnt (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (pwr_ctrl),
    .valid_count_i (valid_count_q),
    .hit_o         (pwr_cnt_hit)
  );

  assign key_hit = key_cnt_hit && key_enable_q;
  assign pwr_hit = pwr_cnt_hit;

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (proc) begin
      out_valid_d = key_hit || pwr_hit;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && (key_hit || pwr_hit)) begin
      out_code_q <= key_hit ? kmsd_position(latch_eff) : 5'd0;
      out_kv_q   <= key_hit;
      out_pe_q   <= pwr_hit;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_code_q};
  assign m_axis_tuser  = {out_pe_q, out_kv_q};

endmodule

FILE: sv/kmsd_checker.sv
// Port-level checker for the keypad matrix scan and debounce unit, with its bind.
module kmsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // stalled output transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output transaction changed while stalled");

  // every result carries a key or a power event
  a_out_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] || m_axis_tuser[1]))
    else $error("empty result emitted");

  // power-only result has a zero key code
  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == 8'd0))
    else $error("key code set without key_valid");

  // accepted key code lies in the position range
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata <= 8'd24))
    else $error("key code out of range");

  // a fresh result follows the input transaction that caused it, through the input and output registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a sample");

endmodule

bind keypad_matrix_scan_debounce_unit kmsd_checker u_kmsd_checker (.*);

FILE: tb/sv/keypad_matrix_scan_debounce_unit_tb.sv
// Testbench for the keypad matrix scan and debounce unit: directed and random scans.
`timescale 1ns / 1ps

module keypad_matrix_scan_debounce_unit_tb;
  import kmsd_pkg::*;

  localparam int unsigned NumColumns  = 6;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned PhaseItems  = 225;

  localparam logic [3:0] RowsIdle = 4'hF;
  localparam logic [3:0] RowPattern [4] = '{4'hE, 4'hD, 4'hB, 4'h7};
  localparam logic [4:0] KeyPosition [25] = '{
    5'd17, 5'd5,  5'd18, 5'd14, 5'd0,  5'd1,  5'd16, 5'd12, 5'd21, 5'd23,
    5'd3,  5'd4,  5'd15, 5'd11, 5'd7,  5'd22, 5'd2,  5'd9,  5'd20, 5'd10,
    5'd6,  5'd19, 5'd13, 5'd8,  5'd24
  };

  typedef struct packed {
    logic       key_valid;
    logic [4:0] key_code;
    logic       power_event;
  } key_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [2:0] column, [6:3] row_lines, [7] power_line
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [4:0] key_code
  logic [1:0]  m_axis_tuser;   // [0] key_valid, [1] power_event
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [15:0] cfg_data_i;

  // debounce mirror
  logic [CountWidth-1:0] valid_cnt;
  logic                  key_en;
  logic [4:0]            latch_code;
  logic [4:0]            cand_code;
  logic [CountWidth-1:0] press_cnt;
  logic                  pwr_seen;
  logic [CountWidth-1:0] pwr_cnt;

  key_result_t expected_keys[$];
  int          mismatches = 0;
  int          cycle_cnt = 0;
  int          samples_sent = 0;
  int          rx_hold_req = 0;
  bit          tx_jitter = 1'b1;
  bit          rx_jitter = 1'b1;

  keypad_matrix_scan_debounce_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("** keypad_matrix_scan_debounce_unit: FAILED **");
      $finish;
    end
  end

  function automatic logic bump_count(inout logic [CountWidth-1:0] cnt);
    if (cnt == CountMax) return 1'b0;
    cnt = cnt + 1'b1;
    return cnt == valid_cnt;
  endfunction

  task automatic debounce_sample(input logic [2:0] col, input logic [3:0] rows,
                                 input logic pwr);
    key_result_t res;
    logic        key_hit;
    logic        pwr_hit;
    res = '0;
    key_hit = 1'b0;
    pwr_hit = 1'b0;
    if (col > LastColumn) return;
    for (int r = 0; r < 4; r++)
      if (rows == RowPattern[r]) latch_code = 5'(r * NumColumns + col);
    if (col != LastColumn) return;
    if (latch_code == NoKey) begin
      cand_code = NoKey;
      press_cnt = '0;
    end else if (latch_code == cand_code) begin
      if (bump_count(press_cnt) && key_en) begin
        key_hit = 1'b1;
        res.key_code = KeyPosition[latch_code];
      end
    end else begin
      cand_code = latch_code;
      press_cnt = '0;
    end
    latch_code = NoKey;
    if (!pwr) begin
      if (pwr_seen) begin
        pwr_hit = bump_count(pwr_cnt);
      end else begin
        pwr_seen = 1'b1;
        pwr_cnt = '0;
      end
    end else begin
      pwr_seen = 1'b0;
      pwr_cnt = '0;
    end
    if (key_hit || pwr_hit) begin
      res.key_valid = key_hit;
      res.power_event = pwr_hit;
      expected_keys.push_back(res);
    end
  endtask

  always @(posedge clk_i)
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      debounce_sample(s_axis_tdata[2:0], s_axis_tdata[6:3], s_axis_tdata[7]);

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch: %s got %0d expected %0d (cycle %0d)", what, got, want, cycle_cnt);
  endtask

  always @(posedge clk_i) begin
    key_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_keys.size() == 0) begin
        report_mismatch("unexpected result, tuser", m_axis_tuser, 0);
      end else begin
        want = expected_keys.pop_front();
        if (m_axis_tuser[0] !== want.key_valid)
          report_mismatch("key_valid", m_axis_tuser[0], want.key_valid);
        if (m_axis_tdata[4:0] !== want.key_code)
          report_mismatch("key_code", m_axis_tdata[4:0], want.key_code);
        if (m_axis_tuser[1] !== want.power_event)
          report_mismatch("power_event", m_axis_tuser[1], want.power_event);
      end
    end
  end

  // receiver: random stalls plus long hold-offs on request
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req != 0) begin
        stall_left = rx_hold_req;
        rx_hold_req = 0;
      end else if (stall_left == 0 && rx_jitter && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic [2:0] col, input logic [3:0] rows, input logic pwr);
    int gap;
    @(negedge clk_i);
    if (tx_jitter && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pwr, rows, col};
    do @(posedge clk_i); while (!s_axis_tready);
    if (col <= LastColumn) samples_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == RegValidCount) valid_cnt = data;
    else key_en = data[0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_keys.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // one scan ending at column 5; key_row < 0 means nothing pressed
  task automatic send_frame(input int key_row, input int key_col, input logic pwr);
    logic [3:0] rows;
    int         first_col;
    first_col = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 5) : 0;
    for (int c = first_col; c < NumColumns; c++) begin
      rows = (key_row >= 0 && c == key_col) ? RowPattern[key_row] : RowsIdle;
      if ($urandom_range(0, 19) == 0) rows = 4'($urandom);
      if ($urandom_range(0, 29) == 0)
        send_sample(3'($urandom_range(6, 7)), 4'($urandom), 1'($urandom));
      if (c == 2 && $urandom_range(0, 15) == 0) c = 3;
      send_sample(3'(c), rows, (c == LastColumn) ? pwr : 1'($urandom));
    end
  endtask

  task automatic test_defaults();
    send_sample(3'd6, RowPattern[0], 1'b0);
    send_sample(3'd7, 4'h0, 1'b1);
    send_sample(LastColumn, RowsIdle, 1'b1);
    send_sample(LastColumn, 4'h0, 1'b1);
    repeat (3) send_sample(LastColumn, RowPattern[3], 1'b0);
    repeat (3) begin
      send_sample(3'd0, RowPattern[0], 1'b1);
      send_sample(LastColumn, RowsIdle, 1'b1);
    end
    send_sample(3'd2, RowPattern[2], 1'b1);
    send_sample(3'd3, 4'h0, 1'b1);
    send_sample(3'd4, RowsIdle, 1'b1);
    send_sample(LastColumn, RowsIdle, 1'b1);
    repeat (3) send_sample(LastColumn, RowsIdle, 1'b0);
    wait_idle();
  endtask

  task automatic test_valid_count_one();
    write_reg(RegValidCount, 16'd1);
    for (int i = 0; i < 8; i++) begin
      send_sample(3'(i % 5), RowPattern[i % 4], 1'b1);
      send_sample(LastColumn, RowsIdle, 1'(i % 3 == 0));
    end
    wait_idle();
  endtask

  task automatic test_key_disable();
    write_reg(RegKeyEnable, 16'd0);
    repeat (3) begin
      send_sample(3'd1, RowPattern[1], 1'b0);
      send_sample(LastColumn, RowsIdle, 1'b0);
    end
    wait_idle();
    write_reg(RegKeyEnable, 16'd1);
  endtask

  task automatic test_valid_count_zero();
    write_reg(RegValidCount, 16'd0);
    repeat (8) send_sample(LastColumn, RowPattern[0], 1'b0);
    wait_idle();
  endtask

  task automatic test_backpressure();
    write_reg(RegValidCount, 16'd1);
    rx_hold_req = 300;
    for (int i = 0; i < 90; i++)
      send_sample(LastColumn, RowPattern[(i / 2) % 4], 1'(i % 3 == 0));
    wait_idle();
  endtask

  // key and power held well past the threshold raise one event each
  task automatic test_long_hold();
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    write_reg(RegValidCount, 16'd100);
    repeat (105) send_sample(LastColumn, RowPattern[0], 1'b0);
    wait_idle();
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
  endtask

  task automatic test_random();
    int key_row, key_col, key_hold, pwr_hold, hold_max, start;
    logic pwr;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       write_reg(RegValidCount, 16'd1);
        1:       write_reg(RegValidCount, 16'd2);
        2:       write_reg(RegValidCount, 16'($urandom_range(3, 5)));
        default: write_reg(RegValidCount, 16'($urandom_range(1, 4)));
      endcase
      write_reg(RegKeyEnable, ($urandom_range(0, 3) != 0) ? 16'd1 : 16'd0);
      if (phase == 5) begin
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
      end
      hold_max = valid_cnt + 3;
      key_hold = 0;
      pwr_hold = 0;
      key_row = -1;
      key_col = 0;
      pwr = 1'b1;
      start = samples_sent;
      while (samples_sent - start < PhaseItems) begin
        if (key_hold == 0) begin
          key_hold = $urandom_range(1, hold_max);
          key_row = ($urandom_range(0, 3) == 0) ? -1 : $urandom_range(0, 3);
          key_col = $urandom_range(0, 5);
        end
        if (pwr_hold == 0) begin
          pwr_hold = $urandom_range(1, hold_max);
          pwr = 1'($urandom_range(0, 2) == 0);
        end
        send_frame(key_row, key_col, pwr);
        key_hold--;
        pwr_hold--;
      end
      wait_idle();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegValidCount;
    cfg_data_i = '0;
    valid_cnt = 16'd2;
    key_en = 1'b1;
    latch_code = NoKey;
    cand_code = NoKey;
    press_cnt = '0;
    pwr_seen = 1'b0;
    pwr_cnt = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_defaults();
    test_valid_count_one();
    test_key_disable();
    test_valid_count_zero();
    test_backpressure();
    test_long_hold();
    test_random();

    if (mismatches == 0) begin
      $display("** keypad_matrix_scan_debounce_unit: PASSED **");
    end else begin
      $display("** keypad_matrix_scan_debounce_unit: FAILED **");
    end
    $finish;
  end

endmodule
